@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ src/hbz_pkg.sv @@
// ----------------------------------------------------------------------------
// hbz_pkg
// Types and constants shared by the hysteresis binarizer modules.
// ----------------------------------------------------------------------------
package hbz_pkg;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 13;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int RST_WIDTH    = 640;
  localparam int RST_HEIGHT   = 480;

  localparam int FIFO_DEPTH = 3;
  localparam int LVL_W      = 2;

  localparam int LINE_W    = 3;
  localparam int LB_ABOVE  = 0;
  localparam int LB_CENTER = 1;
  localparam int LB_WEAK   = 2;

  localparam logic FUNC_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW    = 8'd0,
    REG_HIGH   = 8'd1,
    REG_WIDTH  = 8'd2,
    REG_HEIGHT = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic s;
    logic wk;
    logic va;
    logic vb;
    logic emit;
    logic last;
    logic c0;
    logic left;
    logic hle;
  } item_flags_t;

  typedef struct packed {
    logic binary;
    logic last;
  } result_t;

endpackage

@@ src/hysteresis_binarize_3x3.sv @@
// A pixel's result follows frame_width + 1 items later, via the registered line buffer read
// and then the result queue. Throughput: one item per cycle unless a register write or lack
// of room in the result queue holds the input, set by the single read-modify-write pass per
// item through the line buffer memory (one read port, one write port).
// Reset: synchronous; counters, window, thresholds, frame size and queue are cleared or
// restored. The line buffer is not cleared; unwritten entries are masked by row position.
// ----------------------------------------------------------------------------
// hysteresis_binarize_3x3
// Streaming hysteresis binarizer with a 3x3 strong-mark neighborhood.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hysteresis_binarize_3x3 #(
  parameter int MAX_WIDTH = hbz_pkg::DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] pixel_value
  input  logic [0:0]                     s_axis_tuser,   // [0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [0] binary_value, [7:1] zero
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbz_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hbz_pkg::*;

  logic              restart;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr;
  logic              s2_valid;
  logic [COL_W-1:0]  s2_col;
  item_flags_t       s2_flags;
  logic [LINE_W-1:0] rdata;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [LINE_W-1:0] wr_data;
  logic              push;
  result_t           push_data;
  result_t           out_data;
  logic [LVL_W-1:0]  fifo_level;

  hbz_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_func    (s_axis_tuser[0]),
    .in_pixel   (s_axis_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fifo_level (fifo_level),
    .restart    (restart),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s2_valid   (s2_valid),
    .s2_col     (s2_col),
    .s2_flags   (s2_flags)
  );

  hbz_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  hbz_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .s2_valid  (s2_valid),
    .s2_col    (s2_col),
    .s2_flags  (s2_flags),
    .rdata     (rdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_data (push_data)
  );

  hbz_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .level     (fifo_level)
  );

  assign m_axis_tdata = {7'b0000000, out_data.binary};
  assign m_axis_tlast = out_data.last;

  `ASSERT_NEVER(a_fifo_overflow, clk, rst, push && (fifo_level == LVL_W'(FIFO_DEPTH)) && !(m_axis_tvalid && m_axis_tready))
  `ASSERT_IMPLIES(a_stage_from_transfer, clk, rst, s2_valid, $past(s_axis_tvalid && s_axis_tready))
  `ASSERT_IMPLIES(a_last_is_result, clk, rst, s2_valid && s2_flags.last, push)

endmodule

@@ src/hbz_line_mem.sv @@
// ----------------------------------------------------------------------------
// hbz_line_mem
// Line buffer memory holding the strong and weak marks of the last rows,
// with a registered read and write-first forwarding on a same-address hit.
// ----------------------------------------------------------------------------
module hbz_line_mem #(
  parameter int MAX_WIDTH = hbz_pkg::DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [COL_W-1:0]          waddr,
  input  logic [hbz_pkg::LINE_W-1:0] wdata,
  input  logic                      re,
  input  logic [COL_W-1:0]          raddr,
  output logic [hbz_pkg::LINE_W-1:0] rdata
);
  import hbz_pkg::*;

  logic [LINE_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

@@ src/hbz_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbz_ctrl
// Configuration registers, raster position counters and pixel classification.
// Issues the line buffer read and hands each item to the window stage.
// ----------------------------------------------------------------------------
module hbz_ctrl #(
  parameter int MAX_WIDTH = hbz_pkg::DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int CNT_W = $clog2(MAX_WIDTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [hbz_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hbz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbz_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [hbz_pkg::LVL_W-1:0]      fifo_level,
  output logic                           restart,
  output logic                           rd_en,
  output logic [COL_W-1:0]               rd_addr,
  output logic                           s2_valid,
  output logic [COL_W-1:0]               s2_col,
  output hbz_pkg::item_flags_t           s2_flags
);
  import hbz_pkg::*;

  localparam int CMP_W = (CNT_W > FW_W) ? CNT_W : FW_W;

  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] high_thr;
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [CMP_W-1:0] fw_ext;
  logic [CNT_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             tail;
  logic             accept;
  logic             take;
  logic             col_wrap;
  item_flags_t      flags;

  always_comb begin
    fw_ext = CMP_W'(frame_width);
    if (fw_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(fw_ext);
    end
    if (frame_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (frame_height > FH_W'(HEIGHT_LIMIT)) begin
      h_eff = ROW_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = ROW_W'(frame_height);
    end
  end

  // A register write holds off the input for that cycle.
  assign tail      = row >= h_eff;
  assign in_ready  = !cfg_valid &&
                     (({1'b0, fifo_level} + {{LVL_W{1'b0}}, s2_valid}) <
                      (LVL_W + 1)'(FIFO_DEPTH));
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign take      = accept && !((in_func == FUNC_FLUSH) && !tail);
  assign col_wrap  = (CNT_W'(col) + CNT_W'(1)) >= w_eff;
  assign restart   = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
  assign rd_en     = take;
  assign rd_addr   = col;

  always_comb begin
    flags.s    = !tail && (in_pixel > high_thr);
    flags.wk   = !tail && (in_pixel > low_thr);
    flags.va   = (row >= ROW_W'(2)) && ((row - ROW_W'(2)) < h_eff);
    flags.vb   = (row >= ROW_W'(1)) && ((row - ROW_W'(1)) < h_eff);
    flags.c0   = col == '0;
    flags.emit = (row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0));
    flags.last = (row == ROW_W'(h_eff + ROW_W'(1))) && (col == '0);
    flags.left = (col == '0) ? (w_eff >= CNT_W'(2)) : (col >= COL_W'(2));
    flags.hle  = high_thr <= low_thr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr      <= '0;
      high_thr     <= '0;
      frame_width  <= FW_W'(RST_WIDTH);
      frame_height <= FH_W'(RST_HEIGHT);
      col          <= '0;
      row          <= '0;
      s2_valid     <= 1'b0;
    end else begin
      s2_valid <= take && !cfg_valid;
      if (cfg_valid) begin
        case (cfg_index)
          REG_LOW: begin
            low_thr <= cfg_data[THR_W-1:0];
          end
          REG_HIGH: begin
            high_thr <= cfg_data[THR_W-1:0];
          end
          REG_WIDTH: begin
            frame_width <= cfg_data[FW_W-1:0];
            col         <= '0;
            row         <= '0;
          end
          REG_HEIGHT: begin
            frame_height <= cfg_data[FH_W-1:0];
            col          <= '0;
            row          <= '0;
          end
          default: begin
          end
        endcase
      end else if (take) begin
        if (flags.last) begin
          col <= '0;
          row <= '0;
        end else if (col_wrap) begin
          col <= '0;
          row <= ROW_W'(row + ROW_W'(1));
        end else begin
          col <= COL_W'(col + COL_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_col   <= col;
      s2_flags <= flags;
    end
  end

endmodule

@@ src/hbz_window.sv @@
// ----------------------------------------------------------------------------
// hbz_window
// Read-modify-write stage: merges line buffer data into the 3x3 strong
// window, forms the hysteresis result and writes the updated marks back.
// ----------------------------------------------------------------------------
module hbz_window #(
  parameter int MAX_WIDTH = hbz_pkg::DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic                       s2_valid,
  input  logic [COL_W-1:0]           s2_col,
  input  hbz_pkg::item_flags_t       s2_flags,
  input  logic [hbz_pkg::LINE_W-1:0] rdata,
  output logic                       wr_en,
  output logic [COL_W-1:0]           wr_addr,
  output logic [hbz_pkg::LINE_W-1:0] wr_data,
  output logic                       push,
  output hbz_pkg::result_t           push_data
);
  import hbz_pkg::*;

  logic [8:0] window;
  logic       weak_hold;

  logic [2:0] triple;
  logic [8:0] shifted;
  logic [8:0] used;
  logic [8:0] mask;
  logic       dil;

  always_comb begin
    triple  = {s2_flags.s, rdata[LB_CENTER] & s2_flags.vb, rdata[LB_ABOVE] & s2_flags.va};
    shifted = {triple, window[8:3]};
    used    = s2_flags.c0 ? window : shifted;
    mask    = {{3{!s2_flags.c0}}, 3'b111, {3{s2_flags.left}}};
    dil     = |(used & mask);
    if (s2_flags.hle) begin
      push_data.binary = weak_hold;
    end else begin
      push_data.binary = used[4] | (weak_hold & dil);
    end
    push_data.last = s2_flags.last;
  end

  assign push    = s2_valid && s2_flags.emit;
  assign wr_en   = s2_valid;
  assign wr_addr = s2_col;

  always_comb begin
    wr_data            = '0;
    wr_data[LB_ABOVE]  = rdata[LB_CENTER];
    wr_data[LB_CENTER] = s2_flags.s;
    wr_data[LB_WEAK]   = s2_flags.wk;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window    <= '0;
      weak_hold <= 1'b0;
    end else if (s2_valid) begin
      if (s2_flags.last) begin
        window    <= '0;
        weak_hold <= 1'b0;
      end else begin
        window    <= shifted;
        weak_hold <= rdata[LB_WEAK];
      end
    end
  end

endmodule

@@ src/hbz_out_fifo.sv @@
// ----------------------------------------------------------------------------
// hbz_out_fifo
// Small result queue that decouples the output handshake from the pipeline.
// ----------------------------------------------------------------------------
module hbz_out_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  hbz_pkg::result_t          push_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hbz_pkg::result_t          out_data,
  output logic [hbz_pkg::LVL_W-1:0] level
);
  import hbz_pkg::*;

  result_t          slots [FIFO_DEPTH];
  logic [LVL_W-1:0] head;
  logic [LVL_W-1:0] tail_ptr;
  logic             pop;

  assign out_valid = level != '0;
  assign out_data  = slots[head];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail_ptr <= '0;
      level    <= '0;
    end else begin
      if (push) begin
        tail_ptr <= (tail_ptr == LVL_W'(FIFO_DEPTH - 1)) ? '0 : LVL_W'(tail_ptr + LVL_W'(1));
      end
      if (pop) begin
        head <= (head == LVL_W'(FIFO_DEPTH - 1)) ? '0 : LVL_W'(head + LVL_W'(1));
      end
      if (push && !pop) begin
        level <= LVL_W'(level + LVL_W'(1));
      end else if (pop && !push) begin
        level <= LVL_W'(level - LVL_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail_ptr] <= push_data;
    end
  end

endmodule

@@ bench/hbz_result_check.sv @@
// ----------------------------------------------------------------------------
// hbz_result_check
// Watches the pixel, result and register channels of the hysteresis
// binarizer, predicts every result from its own model of the line buffers and
// the 3x3 strong-mark window, and compares each result transfer field by field
// with the oldest prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module hbz_result_check
  import hbz_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] pixel_value
  input  logic [0:0]            s_axis_tuser,   // [0] func
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [7:0]            m_axis_tdata,   // [0] binary_value, [7:1] zero
  input  logic                  m_axis_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 100;

  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] high_thr;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  logic strong_above [DEF_MAX_WIDTH];
  logic strong_center [DEF_MAX_WIDTH];
  logic weak_center [DEF_MAX_WIDTH];

  int         col;
  int         row;
  int         out_pos;
  logic [8:0] window;
  logic       weak_hold;

  result_t expected_marks [$];
  result_t head;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void restart_frame();
    col = 0;
    row = 0;
    out_pos = 0;
    window = '0;
    weak_hold = 1'b0;
  endfunction

  task automatic binarize_step(input logic is_flush, input logic [PIX_W-1:0] pix);
    int         w;
    int         h;
    int         n;
    int         oc;
    logic       tail;
    logic       emit;
    logic       s;
    logic       wk;
    logic       a;
    logic       b;
    logic       wk_read;
    logic       dil;
    logic [2:0] triple;
    logic [8:0] used;
    logic [8:0] mask;
    result_t    mark;
    w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
    tail = (row >= h);
    // A flush is only meaningful once the frame's pixels are all in.
    if (is_flush && !tail) return;
    n = row * w + col;
    emit = (n >= w + 1);
    s = !tail && (pix > high_thr);
    wk = !tail && (pix > low_thr);
    a = strong_above[col];
    b = strong_center[col];
    wk_read = weak_center[col];
    triple = {s, (row >= 1 && row - 1 < h) && b, (row >= 2 && row - 2 < h) && a};
    if (col == 0) begin
      used = window;
      window = {triple, window[8:3]};
    end else begin
      window = {triple, window[8:3]};
      used = window;
    end
    if (emit) begin
      oc = (col == 0) ? w - 1 : col - 1;
      mask = 9'h038;
      if (oc >= 1) mask |= 9'h007;
      if (oc + 1 < w) mask |= 9'h1C0;
      dil = |(used & mask);
      mark.binary = (high_thr <= low_thr) ? weak_hold : (used[4] | (weak_hold & dil));
      mark.last = (out_pos == w * h - 1);
      expected_marks.push_back(mark);
    end
    strong_above[col] = b;
    strong_center[col] = s;
    weak_center[col] = wk;
    weak_hold = wk_read;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (emit) begin
      out_pos++;
      if (out_pos >= w * h) restart_frame();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      low_thr = '0;
      high_thr = '0;
      width_reg = FW_W'(RST_WIDTH);
      height_reg = FH_W'(RST_HEIGHT);
      foreach (strong_above[i]) begin
        strong_above[i] = 1'b0;
        strong_center[i] = 1'b0;
        weak_center[i] = 1'b0;
      end
      restart_frame();
      expected_marks.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_marks.size() == 0) begin
          report_mismatch("result transfer with no result expected");
        end else begin
          head = expected_marks.pop_front();
          if (m_axis_tdata[0] !== head.binary)
            report_mismatch($sformatf("binary_value %b, expected %b",
                                      m_axis_tdata[0], head.binary));
          if (m_axis_tlast !== head.last)
            report_mismatch($sformatf("last_in_frame %b, expected %b",
                                      m_axis_tlast, head.last));
          if (m_axis_tdata[7:1] !== '0)
            report_mismatch($sformatf("padding bits %b, expected zero", m_axis_tdata[7:1]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW: low_thr = cfg_data[THR_W-1:0];
          REG_HIGH: high_thr = cfg_data[THR_W-1:0];
          REG_WIDTH: begin
            width_reg = cfg_data[FW_W-1:0];
            restart_frame();
          end
          REG_HEIGHT: begin
            height_reg = cfg_data[FH_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        binarize_step(s_axis_tuser[0] == FUNC_FLUSH, s_axis_tdata);
    end
    outstanding = expected_marks.size();
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the hysteresis binarizer with directed frames, saturated frame sizes
// and random frames under bursty input and stalling output, and reports the
// verdict from the mismatch and outstanding counts of the result checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hbz_pkg::*;

  typedef enum int {STEADY, COIN, SPARSE, MOSTLY} stall_mode_t;

  localparam logic FUNC_PIXEL      = ~FUNC_FLUSH;
  localparam int   UNMAPPED_REG    = 255;
  localparam int   NO_STRAY        = -1;
  localparam int   SETTLE_CYCLES   = 8;
  localparam int   TOTAL_ITEMS     = 1150;
  localparam int   TALL_PIXELS     = 24;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam logic [7:0] DIRECTED_PIX [9] = '{8'd0, 8'd255, 8'd100, 8'd101, 8'd200,
                                              8'd201, 8'd150, 8'd50, 8'd255};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] pixel_value
  logic [0:0]            s_axis_tuser = '0;   // [0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [0] binary_value, [7:1] zero
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int items_fed = 0;
  int burst_left = 0;
  bit long_hold_req = 1'b0;

  hysteresis_binarize_3x3 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  hbz_result_check result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return lo + 8'd1;
      2: return hi;
      3: return hi + 8'd1;
      4: return 8'h00;
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic flush, input logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pix;
    s_axis_tuser <= flush;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops offering items and waits until every predicted result has left.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] lo, input logic [7:0] hi,
                           input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                           input bit sizes, input int stray_idx);
    settle();
    if (stray_idx != NO_STRAY) write_reg(CFG_IDX_W'(stray_idx), CFG_DATA_W'($urandom));
    write_reg(REG_LOW, {5'($urandom), lo});
    write_reg(REG_HIGH, {5'($urandom), hi});
    if (sizes) begin
      write_reg(REG_WIDTH, fw);
      write_reg(REG_HEIGHT, fh);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(input int w, input int h, input logic [7:0] lo,
                           input logic [7:0] hi, input bit abandon);
    int stop_at;
    int pause_at;
    stop_at = abandon ? $urandom_range(0, w * h - 1) : w * h;
    pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h - 1) : -1;
    for (int i = 0; i < stop_at; i++) begin
      if (i == pause_at) settle();
      // A flush ahead of the frame's last pixel is dropped by the block.
      if (i > 0 && $urandom_range(0, 24) == 0) send_item(FUNC_FLUSH, 8'($urandom));
      send_item(FUNC_PIXEL, pick_pixel(lo, hi));
      items_fed++;
    end
    if (abandon) return;
    for (int i = 0; i <= w; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(FUNC_PIXEL, 8'($urandom));
      else send_item(FUNC_FLUSH, 8'($urandom));
      items_fed++;
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int          hold_left;
    bit          hold_done;
    mode = STEADY;
    span = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (span == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          STEADY: m_axis_tready <= 1'b1;
          COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          SPARSE: m_axis_tready <= ($urandom_range(0, 5) == 0);
          default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] t;
    int         fw;
    int         fh;
    bit         abandon;
    bit         resize;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Threshold boundaries on a 3x3 frame, with a dropped early flush and a
    // pixel standing in for a flush in the tail.
    configure(8'd100, 8'd200, 13'd3, 13'd3, 1'b1, UNMAPPED_REG);
    for (int i = 0; i < $size(DIRECTED_PIX); i++) begin
      if (i == 5) send_item(FUNC_FLUSH, 8'hFF);
      send_item(FUNC_PIXEL, DIRECTED_PIX[i]);
    end
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);

    // One-row frame: the first flush yields nothing.
    configure(8'd100, 8'd200, 13'd2, 13'd1, 1'b1, NO_STRAY);
    send_item(FUNC_PIXEL, 8'd201);
    send_item(FUNC_PIXEL, 8'd150);
    repeat (3) send_item(FUNC_FLUSH, 8'h00);

    // High threshold below low: the weak mark alone decides.
    configure(8'd200, 8'd100, 13'd1, 13'd2, 1'b1, NO_STRAY);
    send_item(FUNC_PIXEL, 8'd255);
    send_item(FUNC_PIXEL, 8'd150);
    repeat (2) send_item(FUNC_FLUSH, 8'h00);
    items_fed = 20;

    // Frame sizes out of range saturate. The tall and the wide frame are
    // left unfinished; the wide one runs just far enough for its first result.
    configure(8'h00, 8'hFF, 13'd0, 13'd0, 1'b1, NO_STRAY);
    run_frame(1, 1, 8'h00, 8'hFF, 1'b0);
    lo = pick_threshold();
    hi = pick_threshold();
    configure(lo, hi, 13'd1, 13'd8191, 1'b1, NO_STRAY);
    repeat (TALL_PIXELS) begin
      send_item(FUNC_PIXEL, pick_pixel(lo, hi));
      items_fed++;
    end
    lo = pick_threshold();
    hi = pick_threshold();
    configure(lo, hi, 13'd2047, 13'd1, 1'b1, NO_STRAY);
    repeat (DEF_MAX_WIDTH + 2) begin
      send_item(FUNC_PIXEL, pick_pixel(lo, hi));
      items_fed++;
    end

    fw = 32;
    fh = 4;
    resize = 1'b1;
    while (items_fed < TOTAL_ITEMS) begin
      lo = pick_threshold();
      hi = pick_threshold();
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      configure(lo, hi, CFG_DATA_W'(fw), CFG_DATA_W'(fh), resize,
                ($urandom_range(0, 4) == 0) ? $urandom_range(4, 255) : NO_STRAY);
      long_hold_req = 1'b1;
      abandon = ($urandom_range(0, 9) == 0);
      run_frame(fw, fh, lo, hi, abandon);
      resize = abandon || ($urandom_range(0, 3) != 0);
      if (resize) begin
        fw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        fh = $urandom_range(1, 6);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
